// ===== src/ssi_pkg.sv =====
package ssi_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 16;
  localparam int TOL_BITS   = 16;
  localparam int PT_BITS    = 32;

  // differences of coordinates
  localparam int DIFF_BITS  = COORD_BITS + 1;
  // products of two differences
  localparam int PROD_BITS  = 2 * DIFF_BITS;
  // sums of two products
  localparam int DET_BITS   = PROD_BITS + 1;
  // sum of four products (t1)
  localparam int T1_BITS    = PROD_BITS + 2;
  // numerator before scaling: base*den + dir*num
  localparam int ACC_BITS   = COORD_BITS + T1_BITS + 2;
  // magnitude of scaled dividend
  localparam int DVD_BITS   = ACC_BITS + FRAC_BITS;
  // positive divisor magnitude
  localparam int DVS_BITS   = DET_BITS;
  // quotient bits kept by the divider
  localparam int QUO_BITS   = DVD_BITS;
  // divider iterations per pipeline stage
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (QUO_BITS + DIV_STEP - 1) / DIV_STEP;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [PROD_BITS-1:0]  prod_t;
  typedef logic signed [DET_BITS-1:0]   det_t;
  typedef logic signed [T1_BITS-1:0]    t1_t;
  typedef logic signed [ACC_BITS-1:0]   acc_t;

  // one lane of the divider: dividend bits shift out, quotient shifts in
  typedef struct packed {
    logic [DVD_BITS-1:0] dvd;
    logic [DVS_BITS-1:0] rem;
    logic                neg;
  } div_lane_t;

  // result flags that travel alongside the divider
  typedef struct packed {
    logic vld;
    logic hit;
    logic col;
  } div_ctl_t;

  // one restoring divide step
  function automatic logic [DVS_BITS:0] div_try(input logic [DVS_BITS-1:0] rem,
                                                input logic bit_in,
                                                input logic [DVS_BITS-1:0] dvs);
    logic [DVS_BITS:0] sh;
    sh = {rem, bit_in};
    div_try = (sh >= {1'b0, dvs}) ? sh - {1'b0, dvs} : sh;
  endfunction

endpackage

// ===== src/segment_segment_intersection.sv =====
// Two-segment intersection with a fixed-point meeting point.
// Input channel: drive in_seg1_* and in_seg2_* with start high; the word is
// taken on any edge where busy is low. busy is always low in this design, so
// one word can enter every clock cycle.
// Result channel: out_valid strobes for one cycle with out_hit,
// out_collinear_case, out_point_x and out_point_y. The receiver cannot stall
// and results leave in the order their words came in.
// Pipeline: 25 register stages: 5 front stages (differences, products,
// determinants, case decision, dividend forming), one divider entry stage,
// 18 divider stages of 4 quotient bits each and one output register, the
// same for every word.
// Throughput: one word per cycle; the divider is fully unrolled into stages
// and each stage holds one word.
// cfg_we writes cfg_zero_tolerance at the next edge; write it only while no
// word is in flight.
// Reset (rst_n low, synchronous) clears every valid bit and the tolerance;
// words in flight are dropped.
module segment_segment_intersection (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg1_from_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg1_from_y,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg1_to_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg1_to_y,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg2_from_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg2_from_y,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg2_to_x,
  input  logic signed [ssi_pkg::COORD_BITS-1:0] in_seg2_to_y,
  input  logic                                cfg_we,
  input  logic [ssi_pkg::TOL_BITS-1:0]          cfg_zero_tolerance,
  output logic                                out_valid,
  output logic                                out_hit,
  output logic                                out_collinear_case,
  output logic signed [ssi_pkg::PT_BITS-1:0]    out_point_x,
  output logic signed [ssi_pkg::PT_BITS-1:0]    out_point_y
);
  import ssi_pkg::*;

  assign busy = 1'b0;

  // tolerance register
  logic [TOL_BITS-1:0] tol_r;
  always_ff @(posedge clk) begin
    if (!rst_n) tol_r <= '0;
    else if (cfg_we) tol_r <= cfg_zero_tolerance;
  end

  // stage 1: differences
  logic  s1_vld_r;
  coord_t s1_px_r, s1_py_r;
  diff_t s1_rx_r, s1_ry_r, s1_sx_r, s1_sy_r, s1_dx_r, s1_dy_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else s1_vld_r <= start;
  end
  always_ff @(posedge clk) begin
    s1_px_r <= in_seg1_from_x;
    s1_py_r <= in_seg1_from_y;
    s1_rx_r <= DIFF_BITS'(in_seg1_to_x) - DIFF_BITS'(in_seg1_from_x);
    s1_ry_r <= DIFF_BITS'(in_seg1_to_y) - DIFF_BITS'(in_seg1_from_y);
    s1_sx_r <= DIFF_BITS'(in_seg2_to_x) - DIFF_BITS'(in_seg2_from_x);
    s1_sy_r <= DIFF_BITS'(in_seg2_to_y) - DIFF_BITS'(in_seg2_from_y);
    s1_dx_r <= DIFF_BITS'(in_seg2_from_x) - DIFF_BITS'(in_seg1_from_x);
    s1_dy_r <= DIFF_BITS'(in_seg2_from_y) - DIFF_BITS'(in_seg1_from_y);
  end

  // stage 2: all products
  logic  s2_vld_r;
  coord_t s2_px_r, s2_py_r;
  diff_t s2_rx_r, s2_ry_r;
  prod_t s2_rxsy_r, s2_rysx_r, s2_dxry_r, s2_dyrx_r, s2_dxsy_r, s2_dysx_r;
  prod_t s2_rxrx_r, s2_ryry_r, s2_dxrx_r, s2_dyry_r, s2_sxrx_r, s2_syry_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s2_vld_r <= 1'b0;
    else s2_vld_r <= s1_vld_r;
  end
  always_ff @(posedge clk) begin
    s2_px_r   <= s1_px_r;
    s2_py_r   <= s1_py_r;
    s2_rx_r   <= s1_rx_r;
    s2_ry_r   <= s1_ry_r;
    s2_rxsy_r <= PROD_BITS'(s1_rx_r) * PROD_BITS'(s1_sy_r);
    s2_rysx_r <= PROD_BITS'(s1_ry_r) * PROD_BITS'(s1_sx_r);
    s2_dxry_r <= PROD_BITS'(s1_dx_r) * PROD_BITS'(s1_ry_r);
    s2_dyrx_r <= PROD_BITS'(s1_dy_r) * PROD_BITS'(s1_rx_r);
    s2_dxsy_r <= PROD_BITS'(s1_dx_r) * PROD_BITS'(s1_sy_r);
    s2_dysx_r <= PROD_BITS'(s1_dy_r) * PROD_BITS'(s1_sx_r);
    s2_rxrx_r <= PROD_BITS'(s1_rx_r) * PROD_BITS'(s1_rx_r);
    s2_ryry_r <= PROD_BITS'(s1_ry_r) * PROD_BITS'(s1_ry_r);
    s2_dxrx_r <= PROD_BITS'(s1_dx_r) * PROD_BITS'(s1_rx_r);
    s2_dyry_r <= PROD_BITS'(s1_dy_r) * PROD_BITS'(s1_ry_r);
    s2_sxrx_r <= PROD_BITS'(s1_sx_r) * PROD_BITS'(s1_rx_r);
    s2_syry_r <= PROD_BITS'(s1_sy_r) * PROD_BITS'(s1_ry_r);
  end

  // stage 3: determinants and dot products
  logic  s3_vld_r;
  coord_t s3_px_r, s3_py_r;
  diff_t s3_rx_r, s3_ry_r;
  det_t  s3_rxs_r, s3_qpr_r, s3_tn_r, s3_rdr_r, s3_t0_r, s3_sr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s3_vld_r <= 1'b0;
    else s3_vld_r <= s2_vld_r;
  end
  always_ff @(posedge clk) begin
    s3_px_r  <= s2_px_r;
    s3_py_r  <= s2_py_r;
    s3_rx_r  <= s2_rx_r;
    s3_ry_r  <= s2_ry_r;
    s3_rxs_r <= DET_BITS'(s2_rxsy_r) - DET_BITS'(s2_rysx_r);
    s3_qpr_r <= DET_BITS'(s2_dxry_r) - DET_BITS'(s2_dyrx_r);
    s3_tn_r  <= DET_BITS'(s2_dxsy_r) - DET_BITS'(s2_dysx_r);
    s3_rdr_r <= DET_BITS'(s2_rxrx_r) + DET_BITS'(s2_ryry_r);
    s3_t0_r  <= DET_BITS'(s2_dxrx_r) + DET_BITS'(s2_dyry_r);
    s3_sr_r  <= DET_BITS'(s2_sxrx_r) + DET_BITS'(s2_syry_r);
  end

  // stage 4: case decision, pick numerator and denominator
  logic  s4_vld_r, s4_hit_r, s4_col_r;
  coord_t s4_px_r, s4_py_r;
  diff_t s4_rx_r, s4_ry_r;
  t1_t   s4_num_r;
  det_t  s4_den_r;
  logic  hit_nxt, col_nxt;
  t1_t   num_nxt, t0_w, t1_w, rdr_w, tn_w, un_w, d_w;
  det_t  den_nxt;
  logic [DET_BITS-1:0] mrxs_w, mqpr_w;
  logic  zr_w, zq_w;
  always_comb begin
    mrxs_w  = s3_rxs_r[DET_BITS-1] ? -s3_rxs_r : s3_rxs_r;
    mqpr_w  = s3_qpr_r[DET_BITS-1] ? -s3_qpr_r : s3_qpr_r;
    zr_w    = mrxs_w <= DET_BITS'(tol_r);
    zq_w    = mqpr_w <= DET_BITS'(tol_r);
    t0_w    = T1_BITS'(s3_t0_r);
    t1_w    = T1_BITS'(s3_t0_r) + T1_BITS'(s3_sr_r);
    rdr_w   = T1_BITS'(s3_rdr_r);
    tn_w    = s3_rxs_r[DET_BITS-1] ? -T1_BITS'(s3_tn_r) : T1_BITS'(s3_tn_r);
    un_w    = s3_rxs_r[DET_BITS-1] ? -T1_BITS'(s3_qpr_r) : T1_BITS'(s3_qpr_r);
    d_w     = T1_BITS'(mrxs_w);
    hit_nxt = 1'b0;
    col_nxt = 1'b0;
    num_nxt = '0;
    den_nxt = DET_BITS'(1);
    if (zr_w && zq_w) begin
      col_nxt = 1'b1;
      if (s3_rx_r != '0 || s3_ry_r != '0) begin
        den_nxt = s3_rdr_r;
        priority if (t0_w >= 0 && t0_w <= rdr_w) begin
          hit_nxt = 1'b1;
          num_nxt = t0_w;
        end else if (t1_w >= 0 && t1_w <= rdr_w) begin
          hit_nxt = 1'b1;
          num_nxt = t1_w;
        end else if ((t0_w < 0 && t1_w > rdr_w) || (t0_w > rdr_w && t1_w < 0)) begin
          hit_nxt = 1'b1;
        end
      end
    end else if (!zr_w) begin
      if (tn_w >= 0 && tn_w <= d_w && un_w >= 0 && un_w <= d_w) begin
        hit_nxt = 1'b1;
        num_nxt = tn_w;
        den_nxt = DET_BITS'(d_w);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) s4_vld_r <= 1'b0;
    else s4_vld_r <= s3_vld_r;
  end
  always_ff @(posedge clk) begin
    s4_hit_r <= hit_nxt;
    s4_col_r <= col_nxt;
    s4_num_r <= num_nxt;
    s4_den_r <= den_nxt;
    s4_px_r  <= s3_px_r;
    s4_py_r  <= s3_py_r;
    s4_rx_r  <= s3_rx_r;
    s4_ry_r  <= s3_ry_r;
  end

  // stage 5: base*den + dir*num, then sign and magnitude
  logic     s5_vld_r;
  div_ctl_t s5_ctl_r;
  acc_t     s5_ax_r, s5_ay_r;
  logic [DVS_BITS-1:0] s5_dvs_r;
  always_ff @(posedge clk) begin
    if (!rst_n) s5_vld_r <= 1'b0;
    else s5_vld_r <= s4_vld_r;
  end
  always_ff @(posedge clk) begin
    s5_ctl_r <= '{vld: 1'b0, hit: s4_hit_r, col: s4_col_r};
    s5_ax_r  <= ACC_BITS'(s4_px_r) * ACC_BITS'(s4_den_r)
              + ACC_BITS'(s4_rx_r) * ACC_BITS'(s4_num_r);
    s5_ay_r  <= ACC_BITS'(s4_py_r) * ACC_BITS'(s4_den_r)
              + ACC_BITS'(s4_ry_r) * ACC_BITS'(s4_num_r);
    s5_dvs_r <= s4_den_r;
  end

  // divider pipeline, DIV_STEP quotient bits per stage
  div_lane_t xl_r [DIV_STAGES+1];
  div_lane_t yl_r [DIV_STAGES+1];
  div_ctl_t  dc_r [DIV_STAGES+1];
  logic [DVS_BITS-1:0] dvs_r [DIV_STAGES+1];

  logic [ACC_BITS-1:0] magx_w, magy_w;
  assign magx_w = s5_ax_r[ACC_BITS-1] ? ACC_BITS'(-s5_ax_r) : s5_ax_r;
  assign magy_w = s5_ay_r[ACC_BITS-1] ? ACC_BITS'(-s5_ay_r) : s5_ay_r;

  // entry stage of the divider
  always_ff @(posedge clk) begin
    if (!rst_n) dc_r[0].vld <= 1'b0;
    else dc_r[0].vld <= s5_vld_r;
  end
  always_ff @(posedge clk) begin
    dc_r[0].hit <= s5_ctl_r.hit;
    dc_r[0].col <= s5_ctl_r.col;
    xl_r[0]     <= '{dvd: {magx_w, {FRAC_BITS{1'b0}}}, rem: '0, neg: s5_ax_r[ACC_BITS-1]};
    yl_r[0]     <= '{dvd: {magy_w, {FRAC_BITS{1'b0}}}, rem: '0, neg: s5_ay_r[ACC_BITS-1]};
    dvs_r[0]    <= s5_dvs_r;
  end

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    div_lane_t xl_nxt, yl_nxt;
    always_comb begin
      logic [DVS_BITS:0] tx, ty;
      xl_nxt = xl_r[g];
      yl_nxt = yl_r[g];
      for (int k = 0; k < DIV_STEP; k++) begin
        tx = div_try(xl_nxt.rem, xl_nxt.dvd[DVD_BITS-1], dvs_r[g]);
        ty = div_try(yl_nxt.rem, yl_nxt.dvd[DVD_BITS-1], dvs_r[g]);
        xl_nxt.dvd = {xl_nxt.dvd[DVD_BITS-2:0],
                      ({xl_nxt.rem, xl_nxt.dvd[DVD_BITS-1]} >= {1'b0, dvs_r[g]})
                      ? 1'b1 : 1'b0};
        yl_nxt.dvd = {yl_nxt.dvd[DVD_BITS-2:0],
                      ({yl_nxt.rem, yl_nxt.dvd[DVD_BITS-1]} >= {1'b0, dvs_r[g]})
                      ? 1'b1 : 1'b0};
        xl_nxt.rem = tx[DVS_BITS-1:0];
        yl_nxt.rem = ty[DVS_BITS-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (!rst_n) dc_r[g+1].vld <= 1'b0;
      else dc_r[g+1].vld <= dc_r[g].vld;
    end
    always_ff @(posedge clk) begin
      dc_r[g+1].hit <= dc_r[g].hit;
      dc_r[g+1].col <= dc_r[g].col;
      xl_r[g+1]     <= xl_nxt;
      yl_r[g+1]     <= yl_nxt;
      dvs_r[g+1]    <= dvs_r[g];
    end
  end

  // output register: quotient sits in the low dividend bits
  logic [PT_BITS-1:0] qx_w, qy_w;
  localparam int SHIFT_OUT = DIV_STAGES * DIV_STEP - QUO_BITS;
  assign qx_w = PT_BITS'(xl_r[DIV_STAGES].dvd >> SHIFT_OUT);
  assign qy_w = PT_BITS'(yl_r[DIV_STAGES].dvd >> SHIFT_OUT);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else out_valid <= dc_r[DIV_STAGES].vld;
  end
  always_ff @(posedge clk) begin
    out_hit            <= dc_r[DIV_STAGES].hit;
    out_collinear_case <= dc_r[DIV_STAGES].col;
    out_point_x <= !dc_r[DIV_STAGES].hit ? '0 : xl_r[DIV_STAGES].neg ? -qx_w : qx_w;
    out_point_y <= !dc_r[DIV_STAGES].hit ? '0 : yl_r[DIV_STAGES].neg ? -qy_w : qy_w;
  end

endmodule

// ===== dv/segment_segment_intersection_tb.sv =====
`timescale 1ns / 100ps

module segment_segment_intersection_tb;
  import ssi_pkg::*;

  typedef struct {
    logic                      hit;
    logic                      col;
    logic signed [PT_BITS-1:0] px;
    logic signed [PT_BITS-1:0] py;
  } meet_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  coord_t in_seg1_from_x, in_seg1_from_y, in_seg1_to_x, in_seg1_to_y;
  coord_t in_seg2_from_x, in_seg2_from_y, in_seg2_to_x, in_seg2_to_y;
  logic cfg_we;
  logic [TOL_BITS-1:0] cfg_zero_tolerance;
  logic out_valid;
  logic out_hit;
  logic out_collinear_case;
  logic signed [PT_BITS-1:0] out_point_x;
  logic signed [PT_BITS-1:0] out_point_y;

  meet_t meet_q[$];
  logic [TOL_BITS-1:0] tol_shadow;
  int idle_pct;
  int err_cnt;

  segment_segment_intersection DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_seg1_from_x(in_seg1_from_x), .in_seg1_from_y(in_seg1_from_y),
    .in_seg1_to_x(in_seg1_to_x), .in_seg1_to_y(in_seg1_to_y),
    .in_seg2_from_x(in_seg2_from_x), .in_seg2_from_y(in_seg2_from_y),
    .in_seg2_to_x(in_seg2_to_x), .in_seg2_to_y(in_seg2_to_y),
    .cfg_we(cfg_we), .cfg_zero_tolerance(cfg_zero_tolerance),
    .out_valid(out_valid), .out_hit(out_hit), .out_collinear_case(out_collinear_case),
    .out_point_x(out_point_x), .out_point_y(out_point_y)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // (base + dir*num/den) in Q16, truncated toward zero, low 32 bits
  function automatic logic [PT_BITS-1:0] q16_coord(longint base, longint dir,
                                                  longint num, longint den);
    longint acc;
    logic [127:0] m;
    logic [127:0] q;
    acc = base * den + dir * num;
    m = (acc < 0) ? 128'(-acc) : 128'(acc);
    m = m << FRAC_BITS;
    q = m / 128'(den);
    if (acc < 0) q = -q;
    return q[PT_BITS-1:0];
  endfunction

  function automatic meet_t predict_meet(coord_t ax, coord_t ay, coord_t bx, coord_t by,
                                         coord_t cx, coord_t cy, coord_t ex, coord_t ey);
    meet_t m;
    longint px, py, rx, ry, qx, qy, sx, sy, dx, dy, rxs, qpr, num, den;
    longint rdr, t0, t1, tn, un, d;
    logic rz, qz;
    px = ax; py = ay; rx = longint'(bx) - px; ry = longint'(by) - py;
    qx = cx; qy = cy; sx = longint'(ex) - qx; sy = longint'(ey) - qy;
    dx = qx - px; dy = qy - py;
    rxs = rx * sy - ry * sx;
    qpr = dx * ry - dy * rx;
    rz = ((rxs < 0) ? -rxs : rxs) <= longint'(tol_shadow);
    qz = ((qpr < 0) ? -qpr : qpr) <= longint'(tol_shadow);
    m.hit = 1'b0; m.col = 1'b0; num = 0; den = 1;
    if (rz && qz) begin
      // collinear: project second segment onto the first
      m.col = 1'b1;
      if (rx != 0 || ry != 0) begin
        rdr = rx * rx + ry * ry;
        t0 = dx * rx + dy * ry;
        t1 = t0 + sx * rx + sy * ry;
        den = rdr;
        if (t0 >= 0 && t0 <= rdr) begin
          m.hit = 1'b1; num = t0;
        end else if (t1 >= 0 && t1 <= rdr) begin
          m.hit = 1'b1; num = t1;
        end else if ((t0 < 0 && t1 > rdr) || (t0 > rdr && t1 < 0)) begin
          m.hit = 1'b1; num = 0;
        end
      end
    end else if (!rz) begin
      // crossing lines
      tn = dx * sy - dy * sx;
      un = qpr;
      d = rxs;
      if (d < 0) begin
        d = -d; tn = -tn; un = -un;
      end
      if (tn >= 0 && tn <= d && un >= 0 && un <= d) begin
        m.hit = 1'b1; num = tn; den = d;
      end
    end
    m.px = m.hit ? q16_coord(px, rx, num, den) : '0;
    m.py = m.hit ? q16_coord(py, ry, num, den) : '0;
    return m;
  endfunction

  task automatic report_mismatch(string what, longint got, longint exp_v);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_v, $realtime);
    err_cnt++;
  endtask

  // result checker
  always @(posedge clk) begin
    meet_t e;
    if (rst_n && out_valid) begin
      if (meet_q.size() == 0) begin
        report_mismatch("unexpected word", 1, 0);
      end else begin
        e = meet_q.pop_front();
        if (out_hit !== e.hit) report_mismatch("hit", out_hit, e.hit);
        if (out_collinear_case !== e.col) report_mismatch("collinear", out_collinear_case, e.col);
        if (out_point_x !== e.px) report_mismatch("point_x", out_point_x, e.px);
        if (out_point_y !== e.py) report_mismatch("point_y", out_point_y, e.py);
      end
    end
  end

  // send one word, with random idle cycles ahead of it
  task automatic send_word(int ax, int ay, int bx, int by, int cx, int cy, int ex, int ey);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_seg1_from_x <= coord_t'(ax); in_seg1_from_y <= coord_t'(ay);
    in_seg1_to_x <= coord_t'(bx);   in_seg1_to_y <= coord_t'(by);
    in_seg2_from_x <= coord_t'(cx); in_seg2_from_y <= coord_t'(cy);
    in_seg2_to_x <= coord_t'(ex);   in_seg2_to_y <= coord_t'(ey);
    do @(posedge clk); while (busy);
    meet_q = {meet_q, predict_meet(coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
                                   coord_t'(cx), coord_t'(cy), coord_t'(ex), coord_t'(ey))};
    @(negedge clk);
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (meet_q.size() != 0) @(negedge clk);
    repeat (DIV_STAGES + 12) @(negedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_BITS-1:0] v);
    drain_pipe();
    cfg_we <= 1'b1;
    cfg_zero_tolerance <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    tol_shadow = v;
  endtask

  task automatic test_directed();
    idle_pct = 0;
    send_word(0, 0, 10, 10, 0, 10, 10, 0);          // plain crossing
    send_word(0, 0, 10, 0, 10, 0, 10, 5);           // touch at endpoint
    send_word(0, 0, 3, 7, 1, 0, 5, 2);              // fractional miss/hit
    send_word(0, 0, 10, 0, 0, 1, 10, 1);            // parallel disjoint
    send_word(0, 0, 10, 0, 5, 0, 20, 0);            // collinear overlap
    send_word(0, 0, 10, 0, -5, 0, 3, 0);            // collinear, far end inside
    send_word(0, 0, 10, 0, -5, 0, 20, 0);           // containment
    send_word(0, 0, 10, 0, 20, 0, -5, 0);           // containment reversed
    send_word(0, 0, 10, 0, 11, 0, 20, 0);           // collinear disjoint
    send_word(4, 4, 4, 4, 4, 4, 9, 9);              // zero-length first segment
    send_word(-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768);
    send_word(32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768);
    send_word(-32768, 0, 32767, 0, -32768, 0, 32767, 0);
    send_word(-1, -1, 1, 2, 0, -3, 1, 5);
    send_word(0, 0, 32767, 1, 0, 1, 32767, 0);      // nearly parallel
    send_word(0, 0, 1000, 1, 0, 0, 1000, 2);        // small determinant
  endtask

  task automatic test_random(int n);
    int k, kind, bx, by, dx, dy, k0, k1, k2, k3, lim;
    for (k = 0; k < n; k++) begin
      kind = $urandom_range(9);
      if (kind < 2) begin
        // full range
        send_word($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      end else if (kind < 6) begin
        // small box, many crossings
        lim = ($urandom_range(3) == 0) ? 2000 : 20;
        send_word($urandom_range(2*lim) - lim, $urandom_range(2*lim) - lim,
                  $urandom_range(2*lim) - lim, $urandom_range(2*lim) - lim,
                  $urandom_range(2*lim) - lim, $urandom_range(2*lim) - lim,
                  $urandom_range(2*lim) - lim, $urandom_range(2*lim) - lim);
      end else begin
        // points on one line, or on a shifted parallel line
        bx = $urandom_range(40000) - 20000; by = $urandom_range(40000) - 20000;
        dx = $urandom_range(2000) - 1000;   dy = $urandom_range(2000) - 1000;
        if ($urandom_range(3) == 0) begin
          dx = dx % 4; dy = dy % 4;
        end
        k0 = $urandom_range(16) - 8; k1 = $urandom_range(16) - 8;
        k2 = $urandom_range(16) - 8; k3 = $urandom_range(16) - 8;
        lim = (kind == 9) ? $urandom_range(3) - 1 : 0;
        send_word(bx + k0*dx, by + k0*dy, bx + k1*dx, by + k1*dy,
                  bx + k2*dx + lim, by + k2*dy, bx + k3*dx + lim, by + k3*dy);
      end
    end
  endtask

  task automatic test_tolerance_sweep();
    write_tolerance(16'hFFFF);
    idle_pct = 20;
    test_directed();
    test_random(200);
    write_tolerance(16'(($urandom_range(3) == 0) ? $urandom : $urandom_range(200)));
    idle_pct = 45;
    test_random(200);
    write_tolerance(16'h0000);
  endtask

  initial begin
    err_cnt = 0;
    tol_shadow = '0;
    idle_pct = 0;
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_zero_tolerance = '0;
    {in_seg1_from_x, in_seg1_from_y, in_seg1_to_x, in_seg1_to_y} = '0;
    {in_seg2_from_x, in_seg2_from_y, in_seg2_to_x, in_seg2_to_y} = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    idle_pct = 0;
    test_random(400);
    idle_pct = 45;
    test_random(400);
    test_tolerance_sweep();
    idle_pct = 20;
    test_random(400);

    drain_pipe();
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
